[rtl/core/lbpd_pkg.sv]
// ----------------------------------------------------------------------------
// lbpd_pkg
// Shared types and constants of the ladder button peak decoder.
// ----------------------------------------------------------------------------
package lbpd_pkg;

   localparam int THR_BITS      = 10;
   localparam int WIN_BITS      = 16;
   localparam int TIME_BITS     = 32;
   localparam int BAND_BITS     = 20;
   localparam int BAND_COUNT    = 7;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int RSP_BITS      = 8;

   localparam logic [THR_BITS-1:0] THR_RESET = 10'd50;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd50;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GROUND_THR   = 3'd0,
      CSR_SEARCH_WIN   = 3'd1,
      CSR_BANDS_SINGLE = 3'd2,
      CSR_BANDS_PAIRS  = 3'd3,
      CSR_BAND_TRIPLE  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      BTN_NONE = 3'd0,
      BTN_A    = 3'd1,
      BTN_B    = 3'd2,
      BTN_C    = 3'd3,
      BTN_AB   = 3'd4,
      BTN_AC   = 3'd5,
      BTN_BC   = 3'd6,
      BTN_ABC  = 3'd7
   } button_type;

   // low in the lower bits, span above it
   typedef struct packed {
      logic [THR_BITS-1:0] span;
      logic [THR_BITS-1:0] low;
   } band_type;

   // bands[0..2] = A, B, C; bands[3..5] = AB, AC, BC; bands[6] = ABC
   typedef struct packed {
      band_type [BAND_COUNT-1:0] bands;
      logic [WIN_BITS-1:0]       window;
      logic [THR_BITS-1:0]       ground_thr;
   } cfg_type;

   typedef struct packed {
      button_type button;
      logic       pressed;
      logic       unexpected;
   } result_type;

endpackage

[rtl/core/lbpd_csr.sv]
// ----------------------------------------------------------------------------
// lbpd_csr
// Configuration registers: threshold, search window and seven level bands.
// ----------------------------------------------------------------------------
module lbpd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [lbpd_pkg::CSR_IDX_BITS-1:0]     wr_index,
   input  logic [lbpd_pkg::CSR_DATA_BITS-1:0]    wr_data,
   output lbpd_pkg::cfg_type                     cfg
);
   import lbpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_GROUND_THR:   cfg_in.ground_thr  = wr_data[THR_BITS-1:0];
            CSR_SEARCH_WIN:   cfg_in.window      = wr_data[WIN_BITS-1:0];
            CSR_BANDS_SINGLE: cfg_in.bands[2:0]  = wr_data[3*BAND_BITS-1:0];
            CSR_BANDS_PAIRS:  cfg_in.bands[5:3]  = wr_data[3*BAND_BITS-1:0];
            CSR_BAND_TRIPLE:  cfg_in.bands[6]    = wr_data[BAND_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_thr <= THR_RESET;
         cfg_ff.window     <= WIN_RESET;
         cfg_ff.bands      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/lbpd_classify.sv]
// ----------------------------------------------------------------------------
// lbpd_classify
// Match a peak level against the seven bands, first band in order wins.
// ----------------------------------------------------------------------------
module lbpd_classify #(
   parameter int LEVEL_BITS = 10
) (
   input  logic [LEVEL_BITS-1:0]                       level,
   input  lbpd_pkg::band_type [lbpd_pkg::BAND_COUNT-1:0] bands,
   output lbpd_pkg::button_type                        button
);
   import lbpd_pkg::*;

   logic [LEVEL_BITS-1:0] low_ext  [BAND_COUNT];
   logic [LEVEL_BITS-1:0] span_ext [BAND_COUNT];
   logic [LEVEL_BITS-1:0] diff     [BAND_COUNT];
   logic [BAND_COUNT-1:0] hit;

   always_comb begin
      for (int i = 0; i < BAND_COUNT; i++) begin
         low_ext[i]  = LEVEL_BITS'(bands[i].low);
         span_ext[i] = LEVEL_BITS'(bands[i].span);
         diff[i]     = level - low_ext[i];
         hit[i]      = (level >= low_ext[i]) && (diff[i] <= span_ext[i]);
      end
   end

   always_comb begin
      priority if (hit[0]) button = BTN_A;
      else if (hit[1])     button = BTN_B;
      else if (hit[2])     button = BTN_C;
      else if (hit[3])     button = BTN_AB;
      else if (hit[4])     button = BTN_AC;
      else if (hit[5])     button = BTN_BC;
      else if (hit[6])     button = BTN_ABC;
      else                 button = BTN_NONE;
   end

endmodule

[rtl/core/lbpd_tracker.sv]
// ----------------------------------------------------------------------------
// lbpd_tracker
// Press state, peak hold over the search window and the one-shot decision.
// ----------------------------------------------------------------------------
module lbpd_tracker #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [lbpd_pkg::TIME_BITS-1:0]   now_ms,
   input  lbpd_pkg::cfg_type                cfg,
   output lbpd_pkg::result_type             result
);
   import lbpd_pkg::*;

   localparam int LEVEL_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   logic                   pressed_last_ff, pressed_last_in;
   logic [TIME_BITS-1:0]   press_start_ff, press_start_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic                   decided_ff, decided_in;

   logic                   hit;
   logic                   new_press;
   logic [TIME_BITS-1:0]   elapsed;
   logic [TIME_BITS-1:0]   window_ext;
   logic                   in_window;
   logic                   decide;
   button_type             code;

   always_comb begin
      hit        = LEVEL_BITS'(sample) > LEVEL_BITS'(cfg.ground_thr);
      new_press  = hit && !pressed_last_ff;
      press_start_in  = new_press ? now_ms : press_start_ff;
      pressed_last_in = hit;
      elapsed    = now_ms - press_start_in;
      window_ext = TIME_BITS'(cfg.window);
      in_window  = elapsed < window_ext;

      peak_in = peak_ff;
      if (hit) begin
         if (in_window && (sample > peak_ff)) begin
            peak_in = sample;
         end
      end else if (pressed_last_ff) begin
         // release drops the held peak
         peak_in = '0;
      end

      decide     = !(decided_ff && !new_press) && (elapsed > window_ext);
      decided_in = (decided_ff && !new_press) || decide;

      result.button     = decide ? code : BTN_NONE;
      result.pressed    = decide && (code != BTN_NONE);
      result.unexpected = decide && (code == BTN_NONE);
   end

   lbpd_classify #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_classify (
      .level  (LEVEL_BITS'(peak_in)),
      .bands  (cfg.bands),
      .button (code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_last_ff <= 1'b0;
         press_start_ff  <= '0;
         peak_ff         <= '0;
         decided_ff      <= 1'b1;
      end else if (step) begin
         pressed_last_ff <= pressed_last_in;
         press_start_ff  <= press_start_in;
         peak_ff         <= peak_in;
         decided_ff      <= decided_in;
      end
   end

endmodule

[rtl/core/ladder_button_peak_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ladder_button_peak_decoder_unit
// Resistor-ladder keypad decoder with peak hold and band classification.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one poll beat: an ADC sample of the ladder line and the
//   current millisecond time. rsp_* returns exactly one result beat per
//   poll, in order: button code, a pressed flag and an unexpected-level flag.
//   All fields are zero for a poll that makes no decision.
//   csr_* writes one configuration register per beat (index, data); write
//   only while no poll is in flight. csr_ready is always high.
// Timing:
//   A poll is held in the input register, is evaluated against the
//   press state and lands in the result register, which drives rsp_tvalid.
//   One poll per cycle is sustained while rsp_tready stays high; the press
//   state update and seven band compares fit in that single stage.
// Reset:
//   Synchronous, active high. Clears the valid flags of both pipeline registers,
//   the press state (no press, nothing pending) and loads the register defaults.
// Backpressure:
//   While rsp_tready is low the result holds, the input register holds
//   behind it and req_tready drops once both are full.
// ----------------------------------------------------------------------------
module ladder_button_peak_decoder_unit #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [SAMPLE_BITS-1:0] sample, [SAMPLE_BITS+31:SAMPLE_BITS] now_ms, zero pad
   input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] button, [3] pressed, [4] unexpected_level, [7:5] zero
   output logic [lbpd_pkg::RSP_BITS-1:0]        rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lbpd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lbpd_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import lbpd_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic                   advance;
   logic                   req_take;

   assign csr_ready = 1'b1;

   lbpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   lbpd_tracker #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (sample_ff),
      .now_ms (now_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || advance;
      req_take   = req_tvalid && req_tready;

      s1_valid_in = req_take || (s1_valid_ff && !advance);
      sample_in   = req_take ? req_tdata[SAMPLE_BITS-1:0] : sample_ff;
      now_in      = req_take ? req_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS] : now_ff;

      // hold the result until taken
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      now_ff    <= now_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.unexpected, rsp_ff.pressed, rsp_ff.button};

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.pressed && rsp_ff.unexpected))
      else $error("pressed and unexpected set together");

   a_pressed_has_button: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pressed) |-> (rsp_ff.button != BTN_NONE))
      else $error("pressed without a button code");

   a_unexpected_no_button: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.unexpected) |-> (rsp_ff.button == BTN_NONE))
      else $error("unexpected level with a button code");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(now_ff) && $stable(sample_ff)))
      else $error("stalled poll lost from input register");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ladder button peak decoder.
//
// Polls are queued by a stimulus process, then driven on req_* by a clocked
// driver. A monitor predicts each accepted poll against its own model of the
// press state and band table, and checks every result beat on rsp_* in order.
// The run goes through the register defaults and a short directed sequence,
// then several random register settings. Each setting mostly sends well-formed
// press/hold/release runs, mixed with noise. Backpressure varies from phase
// to phase, and one long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
   import lbpd_pkg::*;

   localparam int SAMPLE_W        = 10;
   localparam int REQ_BITS        = ((SAMPLE_W + TIME_BITS + 7) / 8) * 8;
   localparam int MAX_LEVEL       = (1 << SAMPLE_W) - 1;
   localparam int RSP_PRESSED_BIT = 3;
   localparam int RSP_UNEXP_BIT   = 4;
   localparam int DRAIN_CYCLES    = 6;
   localparam int QUIET_LIMIT     = 2000;
   localparam int LONG_STALL      = 400;
   localparam int STALL_AFTER     = 150;
   localparam int REPORT_CAP      = 100;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [TIME_BITS-1:0] now;
      logic [SAMPLE_W-1:0]  level;
   } poll_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_DATA_BITS-1:0] csr_data   = '0;

   ladder_button_peak_decoder_unit #(
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   poll_type   poll_q[$];
   result_type expected_q[$];

   bit req_fire;
   bit rsp_fire;
   bit csr_fire;
   int quiet_cycles;
   int polls_accepted;
   int results_checked;
   int buttons_seen;
   int unmatched_seen;
   int settings_loaded;
   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;
   bit long_stall_done;

   // predictor state and registers
   logic [THR_BITS-1:0]  prd_thr;
   logic [WIN_BITS-1:0]  prd_win;
   band_type             prd_band [BAND_COUNT];
   logic                 prd_down;
   logic [TIME_BITS-1:0] prd_start;
   logic [SAMPLE_W-1:0]  prd_peak;
   logic                 prd_settled;

   // generator's view of the current setting
   logic [TIME_BITS-1:0] gen_now;
   logic [THR_BITS-1:0]  gen_thr;
   logic [WIN_BITS-1:0]  gen_win;
   band_type             gen_band [BAND_COUNT];

   task automatic report_mismatch(input string msg);
      if (error_count < REPORT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic band_type band_of(input logic [CSR_DATA_BITS-1:0] word, input int slot);
      return word[BAND_BITS*slot +: BAND_BITS];
   endfunction

   function automatic logic [BAND_BITS-1:0] pack_band(input int low, input int span);
      band_type b;
      b.low  = low[THR_BITS-1:0];
      b.span = span[THR_BITS-1:0];
      return b;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_GROUND_THR: prd_thr = data[THR_BITS-1:0];
         CSR_SEARCH_WIN: prd_win = data[WIN_BITS-1:0];
         CSR_BANDS_SINGLE: begin
            for (int k = 0; k < 3; k++) prd_band[k] = band_of(data, k);
         end
         CSR_BANDS_PAIRS: begin
            for (int k = 0; k < 3; k++) prd_band[3+k] = band_of(data, k);
         end
         CSR_BAND_TRIPLE: prd_band[BAND_COUNT-1] = band_of(data, 0);
         default: ;
      endcase
   endfunction

   // lowest slot wins where bands overlap
   function automatic button_type classify_peak(input logic [SAMPLE_W-1:0] lvl);
      button_type code;
      code = BTN_NONE;
      for (int k = BAND_COUNT - 1; k >= 0; k--) begin
         if (lvl >= prd_band[k].low && (lvl - prd_band[k].low) <= prd_band[k].span) begin
            code = button_type'(k + 1);
         end
      end
      return code;
   endfunction

   function automatic result_type predict_poll(input logic [SAMPLE_W-1:0] level,
                                               input logic [TIME_BITS-1:0] now);
      result_type           outcome;
      logic [TIME_BITS-1:0] elapsed;
      button_type           code;
      outcome = '0;
      if (level > prd_thr) begin
         if (!prd_down) begin
            prd_start   = now;
            prd_down    = 1'b1;
            prd_settled = 1'b0;
         end
         elapsed = now - prd_start;
         if (elapsed < prd_win && level > prd_peak) prd_peak = level;
      end else if (prd_down) begin
         prd_peak = '0;
         prd_down = 1'b0;
      end
      elapsed = now - prd_start;
      if (!prd_settled && elapsed > prd_win) begin
         code = classify_peak(prd_peak);
         if (code != BTN_NONE) begin
            outcome.button  = code;
            outcome.pressed = 1'b1;
         end else begin
            outcome.unexpected = 1'b1;
         end
         prd_settled = 1'b1;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         prd_thr     = THR_RESET;
         prd_win     = WIN_RESET;
         foreach (prd_band[k]) prd_band[k] = '0;
         prd_down    = 1'b0;
         prd_start   = '0;
         prd_peak    = '0;
         prd_settled = 1'b1;
         req_fire    = 1'b0;
         rsp_fire    = 1'b0;
         csr_fire    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire = req_tvalid && req_tready;
         rsp_fire = rsp_tvalid && rsp_tready;
         csr_fire = csr_valid && csr_ready;
         if (csr_fire) apply_reg(csr_index, csr_data);
         if (req_fire) begin
            expected_q.push_back(predict_poll(req_tdata[SAMPLE_W-1:0],
                                              req_tdata[SAMPLE_W +: TIME_BITS]));
            polls_accepted++;
         end
         if (rsp_fire) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result beat %h with no poll waiting", rsp_tdata));
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (want.pressed) buttons_seen++;
               if (want.unexpected) unmatched_seen++;
               if (rsp_tdata[2:0] !== want.button ||
                   rsp_tdata[RSP_PRESSED_BIT] !== want.pressed ||
                   rsp_tdata[RSP_UNEXP_BIT] !== want.unexpected) begin
                  report_mismatch($sformatf(
                     "result %0d: button %0d pressed %b unexpected %b, want %0d %b %b",
                     results_checked, rsp_tdata[2:0], rsp_tdata[RSP_PRESSED_BIT],
                     rsp_tdata[RSP_UNEXP_BIT], want.button, want.pressed, want.unexpected));
               end
            end
         end
         if (req_fire || rsp_fire || csr_fire) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, expected_q.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : poll_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fire) poll_q.delete(0);
         // hold an offered beat until it is taken
         if (!req_tvalid || req_fire) begin
            if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_BITS'(poll_q[0]);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin : rsp_pacer
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!long_stall_done && polls_accepted >= STALL_AFTER) begin
         // hold off long enough for the input side to back up
         long_stall_done = 1'b1;
         stall_left      = LONG_STALL;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_poll(input int level, input logic [TIME_BITS-1:0] now);
      poll_type p;
      p.level = level[SAMPLE_W-1:0];
      p.now   = now;
      poll_q.push_back(p);
   endtask

   // call at a falling edge; returns at the falling edge after the beat
   task automatic csr_beat(input logic [CSR_IDX_BITS-1:0] idx,
                           input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_fire);
   endtask

   task automatic load_settings(input logic [CSR_DATA_BITS-1:0] thr, win, single, pairs,
                                triple, input bit spare);
      @(negedge clock);
      csr_beat(CSR_GROUND_THR, thr);
      csr_beat(CSR_SEARCH_WIN, win);
      csr_beat(CSR_BANDS_SINGLE, single);
      csr_beat(CSR_BANDS_PAIRS, pairs);
      csr_beat(CSR_BAND_TRIPLE, triple);
      if (spare) begin
         csr_beat(CSR_IDX_BITS'($urandom_range(CSR_UNUSED_LAST, CSR_UNUSED_FIRST)),
                  {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      gen_thr = thr[THR_BITS-1:0];
      gen_win = win[WIN_BITS-1:0];
      for (int k = 0; k < 3; k++) begin
         gen_band[k]   = band_of(single, k);
         gen_band[3+k] = band_of(pairs, k);
      end
      gen_band[BAND_COUNT-1] = band_of(triple, 0);
      settings_loaded++;
   endtask

   task automatic wait_drained();
      while (poll_q.size() != 0 || expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_bands(input bit wide);
      logic [CSR_DATA_BITS-1:0] word;
      word = '0;
      for (int k = 0; k < 3; k++) begin
         word[BAND_BITS*k +: BAND_BITS] =
            pack_band($urandom_range(MAX_LEVEL), wide ? $urandom_range(MAX_LEVEL)
                                                      : $urandom_range(80));
      end
      return word;
   endfunction

   function automatic int press_level();
      if (gen_thr == MAX_LEVEL) return MAX_LEVEL;
      return $urandom_range(MAX_LEVEL, gen_thr + 1);
   endfunction

   function automatic int quiet_level();
      return $urandom_range(gen_thr, 0);
   endfunction

   // aim at a band, its edges included; fall back to any pressed level
   function automatic int aim_level();
      band_type b;
      int       v;
      b = gen_band[$urandom_range(BAND_COUNT - 1)];
      case ($urandom_range(4))
         0: v = int'(b.low) - 1;
         1: v = int'(b.low);
         2: v = int'(b.low) + int'(b.span);
         3: v = int'(b.low) + int'(b.span) + 1;
         default: v = int'(b.low) + int'($urandom_range(b.span));
      endcase
      if (v < 0 || v > MAX_LEVEL || v <= int'(gen_thr)) return press_level();
      return v;
   endfunction

   task automatic gen_traffic(input int count);
      int                   made;
      int                   reps;
      logic [TIME_BITS-1:0] t0;
      logic [TIME_BITS-1:0] off;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 80) begin
            reps = $urandom_range(2);
            repeat (reps) begin
               push_poll(quiet_level(), gen_now);
               gen_now += $urandom_range(8, 1);
               made++;
            end
            if ($urandom_range(9) == 0) gen_now = $urandom;
            t0  = gen_now;
            off = '0;
            push_poll(aim_level(), t0);
            made++;
            reps = $urandom_range(3);
            repeat (reps) begin
               off = off + $urandom_range(gen_win / 3 + 1);
               if (off > gen_win) off = TIME_BITS'(gen_win);
               push_poll(($urandom_range(3) == 0) ? aim_level() : press_level(), t0 + off);
               made++;
            end
            off = gen_win + 1 + $urandom_range(3);
            if ($urandom_range(9) == 0) begin
               // let go after the window, so the decision classifies the cleared peak
               push_poll(quiet_level(), t0 + off);
               made++;
            end else begin
               push_poll(press_level(), t0 + off);
               push_poll(quiet_level(), t0 + off + $urandom_range(5, 1));
               made += 2;
            end
            gen_now = t0 + off + 6 + $urandom_range(20);
         end else begin
            push_poll($urandom_range(MAX_LEVEL), gen_now);
            made++;
            case ($urandom_range(3))
               0: gen_now += $urandom_range(3);
               1: gen_now += gen_win;
               2: gen_now += gen_win + 1;
               default: gen_now = $urandom;
            endcase
         end
      end
   endtask

   initial begin : stimulus
      logic [TIME_BITS-1:0] at;
      int                   aim [BAND_COUNT];
      aim = '{210, 310, 410, 510, 610, 820, MAX_LEVEL};
      gen_now = '0;
      gen_thr = THR_RESET;
      gen_win = WIN_RESET;
      foreach (gen_band[k]) gen_band[k] = '0;
      send_idle_pct = 35;
      recv_idle_pct = 66;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: a full-scale peak matches none of the zero bands
      push_poll(MAX_LEVEL, 32'd0);
      push_poll(60, 32'd51);
      push_poll(0, 32'd60);
      wait_drained();

      // one band per button; BC overlaps the low end of ABC
      load_settings(100, 20,
                    {4'b0, pack_band(400, 49), pack_band(300, 49), pack_band(200, 49)},
                    {4'b0, pack_band(700, 149), pack_band(600, 49), pack_band(500, 49)},
                    CSR_DATA_BITS'(pack_band(800, 223)), 1'b0);
      at = 32'd1000;
      for (int k = 0; k < BAND_COUNT; k++) begin
         push_poll(aim[k], at);
         // a sample right at the window edge neither raises the peak nor decides
         if (k == 0) push_poll(1000, at + 20);
         push_poll(150, at + 21);
         push_poll(10, at + 25);
         at += 100;
      end
      // peak between bands, press running across the time wrap
      at = 32'hFFFF_FFFF;
      push_poll(270, at);
      push_poll(120, at + 21);
      push_poll(10, at + 25);
      // release after the window: the cleared peak is what gets classified
      push_poll(450, 32'd5000);
      push_poll(0, 32'd5030);
      wait_drained();

      load_settings(CSR_DATA_BITS'($urandom_range(300, 20)),
                    CSR_DATA_BITS'($urandom_range(60, 5)), random_bands(1'b0),
                    random_bands(1'b0), random_bands(1'b0), 1'b1);
      gen_traffic(110);
      wait_drained();

      send_idle_pct = 66;
      recv_idle_pct = 35;
      load_settings(0, 0, random_bands(1'b1), random_bands(1'b1), random_bands(1'b1), 1'b0);
      gen_traffic(90);
      wait_drained();

      load_settings(CSR_DATA_BITS'(MAX_LEVEL), CSR_DATA_BITS'(16'hFFFF), random_bands(1'b0),
                    random_bands(1'b0), random_bands(1'b0), 1'b0);
      gen_traffic(15);
      wait_drained();

      load_settings(CSR_DATA_BITS'(MAX_LEVEL - 1), CSR_DATA_BITS'(16'hFFFF),
                    random_bands(1'b0), random_bands(1'b0),
                    CSR_DATA_BITS'(pack_band(MAX_LEVEL, 0)), 1'b0);
      gen_traffic(60);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      gen_traffic(130);
      wait_drained();

      load_settings(CSR_DATA_BITS'($urandom_range(200)), CSR_DATA_BITS'($urandom_range(40)),
                    random_bands(1'b1), random_bands(1'b0), random_bands(1'b1), 1'b0);
      gen_now = 32'hFFFF_FFFF - $urandom_range(500);
      gen_traffic(130);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Checked %0d poll results across %0d register settings.",
               results_checked, settings_loaded);
      $display("Decisions: %0d buttons, %0d unmatched peaks; long receiver stall %0s.",
               buttons_seen, unmatched_seen, long_stall_done ? "applied" : "not reached");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
